// File: hdl/intel_hex_record_parser_top_defines.svh
// ----------------------------------------------------------------------------
// Intel HEX record parser assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef INTEL_HEX_RECORD_PARSER_TOP_DEFINES_SVH
`define INTEL_HEX_RECORD_PARSER_TOP_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define IHEX_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while in reset
`define IHEX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/ihex_pkg.sv
// ----------------------------------------------------------------------------
// Intel HEX parser package
// Phase and result codes, record constants and the hex digit decoder.
// ----------------------------------------------------------------------------
package ihex_pkg;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_COUNT = 3'd1,
        PH_ADDR  = 3'd2,
        PH_TYPE  = 3'd3,
        PH_DATA  = 3'd4,
        PH_CSUM  = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_END  = 2'd1,
        KIND_EOF  = 2'd2
    } t_kind;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] TYPE_DATA  = 8'h00;
    localparam logic [7:0] TYPE_EOF   = 8'h01;
    localparam logic [3:0] NIB_TEN    = 4'hA;

    typedef struct packed {
        logic        vld;
        t_kind       kind;
        logic [15:0] byte_address;
        logic [7:0]  byte_value;
        logic        checksum_ok;
    } t_result;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] nib;
    } t_digit;

    function automatic t_digit hex_decode(input logic [7:0] c);
        t_digit d;
        d.is_hex = 1'b1;
        d.nib    = 4'h0;
        if (c inside {[8'h30:8'h39]}) begin
            d.nib = c[3:0];
        end else if (c inside {[8'h61:8'h66]}) begin
            d.nib = 4'(c - 8'h61) + NIB_TEN;
        end else if (c inside {[8'h41:8'h46]}) begin
            d.nib = 4'(c - 8'h41) + NIB_TEN;
        end else begin
            d.is_hex = 1'b0;
        end
        return d;
    endfunction

endpackage

// File: hdl/ihex_if.sv
// ----------------------------------------------------------------------------
// Intel HEX parser stream interfaces
// Character input channel and result output channel, valid/ready.
// ----------------------------------------------------------------------------
interface ihex_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ascii_char;

    modport source (output valid, output ascii_char, input ready);
    modport sink   (input valid, input ascii_char, output ready);
endinterface

interface ihex_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] byte_address;
    logic [7:0]  byte_value;
    logic        checksum_ok;

    modport source (output valid, output kind, output byte_address,
                    output byte_value, output checksum_ok, input ready);
    modport sink   (input valid, input kind, input byte_address,
                    input byte_value, input checksum_ok, output ready);
endinterface

// File: hdl/intel_hex_record_parser_top.sv
// ----------------------------------------------------------------------------
// Intel HEX record parser, top level
// Pipeline: input character register, then the record state engine, then the result register driving o_out.
// Throughput: one character beat per cycle; stalls only on output backpressure.
// Reset: synchronous, active low; parser returns to idle waiting for a colon.
// ----------------------------------------------------------------------------
module intel_hex_record_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ihex_in_if.sink     i_in,
    ihex_out_if.source  o_out
);
    import ihex_pkg::*;

    logic       r_in_vld;
    logic [7:0] r_in_char;
    logic       r_out_vld;
    t_result    r_out;
    t_result    w_res;
    logic       w_adv;

    // whole pipe moves unless a held result is not being taken
    assign w_adv      = !r_out_vld || o_out.ready;
    assign i_in.ready = w_adv;

    ihex_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv && r_in_vld),
        .i_char  (r_in_char),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_in_vld  <= i_in.valid;
            r_out_vld <= r_in_vld && w_res.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_in_char <= i_in.ascii_char;
            r_out     <= w_res;
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.kind         = r_out.kind;
    assign o_out.byte_address = r_out.byte_address;
    assign o_out.byte_value   = r_out.byte_value;
    assign o_out.checksum_ok  = r_out.checksum_ok;

endmodule

// File: hdl/ihex_parser.sv
// ----------------------------------------------------------------------------
// Intel HEX record state engine
// Consumes one character per enable, updates record state, forms a result.
// ----------------------------------------------------------------------------
module ihex_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [7:0]       i_char,
    output ihex_pkg::t_result o_res
);
    import ihex_pkg::*;

    t_phase      r_phase, n_phase;
    logic        r_second, n_second;
    logic [3:0]  r_high, n_high;
    logic [7:0]  r_count, n_count;
    logic [15:0] r_addr, n_addr;
    logic [1:0]  r_adc, n_adc;
    logic [7:0]  r_type, n_type;
    logic [7:0]  r_bd, n_bd;
    logic [7:0]  r_sum, n_sum;
    logic        r_finished, n_finished;

    t_digit      w_dig;
    logic        w_live, w_colon, w_digit;
    logic        w_addr_step, w_hi_step, w_byte_step;
    logic [7:0]  w_byte, w_sum, w_bd_inc;
    logic [15:0] w_addr_shift;

    always_comb begin
        w_dig        = hex_decode(i_char);
        w_colon      = (i_char == CHAR_COLON);
        w_live       = i_en && !r_finished;
        w_digit      = w_live && !w_colon && w_dig.is_hex && (r_phase != PH_IDLE);
        w_addr_step  = w_digit && (r_phase == PH_ADDR);
        w_hi_step    = w_digit && (r_phase != PH_ADDR) && !r_second;
        w_byte_step  = w_digit && (r_phase != PH_ADDR) && r_second;
        w_byte       = {r_high, w_dig.nib};
        w_sum        = r_sum + w_byte;
        w_bd_inc     = r_bd + 8'd1;
        w_addr_shift = {r_addr[11:0], w_dig.nib};
    end

    // phase sequencing
    always_comb begin
        n_phase = r_phase;
        if (w_live && w_colon) begin
            n_phase = PH_COUNT;
        end else if (w_addr_step) begin
            if (r_adc == 2'd3) begin
                n_phase = PH_TYPE;
            end
        end else if (w_byte_step) begin
            case (r_phase)
                PH_COUNT: n_phase = PH_ADDR;
                PH_TYPE: begin
                    if (w_byte == TYPE_EOF) begin
                        n_phase = PH_IDLE;
                    end else if (r_count == 8'd0) begin
                        n_phase = PH_CSUM;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end
                PH_DATA: begin
                    if (w_bd_inc == r_count) begin
                        n_phase = PH_CSUM;
                    end
                end
                PH_CSUM: n_phase = PH_IDLE;
                default: n_phase = r_phase;
            endcase
        end
    end

    // record fields and result
    always_comb begin
        n_second   = r_second;
        n_high     = r_high;
        n_count    = r_count;
        n_addr     = r_addr;
        n_adc      = r_adc;
        n_type     = r_type;
        n_bd       = r_bd;
        n_sum      = r_sum;
        n_finished = r_finished;
        o_res      = '0;
        o_res.kind = KIND_DATA;

        if (w_live && w_colon) begin
            n_second = 1'b0;
            n_high   = 4'h0;
            n_adc    = 2'd0;
            n_bd     = 8'd0;
            n_sum    = 8'd0;
        end else if (w_addr_step) begin
            n_addr = w_addr_shift;
            if (r_adc == 2'd3) begin
                n_adc = 2'd0;
                n_sum = r_sum + w_addr_shift[15:8] + w_addr_shift[7:0];
            end else begin
                n_adc = r_adc + 2'd1;
            end
        end else if (w_hi_step) begin
            n_high   = w_dig.nib;
            n_second = 1'b1;
        end else if (w_byte_step) begin
            n_second = 1'b0;
            n_sum    = w_sum;
            case (r_phase)
                PH_COUNT: begin
                    n_count = w_byte;
                    n_addr  = 16'd0;
                    n_adc   = 2'd0;
                end
                PH_TYPE: begin
                    n_type = w_byte;
                    if (w_byte == TYPE_EOF) begin
                        n_finished         = 1'b1;
                        o_res.vld          = 1'b1;
                        o_res.kind         = KIND_EOF;
                        o_res.byte_address = r_addr;
                    end else begin
                        n_bd = 8'd0;
                    end
                end
                PH_DATA: begin
                    n_bd = w_bd_inc;
                    if (r_type == TYPE_DATA) begin
                        o_res.vld          = 1'b1;
                        o_res.kind         = KIND_DATA;
                        o_res.byte_address = r_addr + {8'd0, r_bd};
                        o_res.byte_value   = w_byte;
                    end
                end
                PH_CSUM: begin
                    o_res.vld         = 1'b1;
                    o_res.kind        = KIND_END;
                    o_res.byte_value  = w_byte;
                    o_res.checksum_ok = (w_sum == 8'd0);
                end
                default: n_second = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_second   <= 1'b0;
            r_high     <= 4'h0;
            r_count    <= 8'd0;
            r_addr     <= 16'd0;
            r_adc      <= 2'd0;
            r_type     <= 8'd0;
            r_bd       <= 8'd0;
            r_sum      <= 8'd0;
            r_finished <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_second   <= n_second;
            r_high     <= n_high;
            r_count    <= n_count;
            r_addr     <= n_addr;
            r_adc      <= n_adc;
            r_type     <= n_type;
            r_bd       <= n_bd;
            r_sum      <= n_sum;
            r_finished <= n_finished;
        end
    end

endmodule

// File: hdl/ihex_checker.sv
// ----------------------------------------------------------------------------
// Intel HEX parser port checker
// Result-field consistency and end-of-file finality seen at the ports.
// ----------------------------------------------------------------------------
`include "intel_hex_record_parser_top_defines.svh"

module ihex_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_out_kind,
    input logic [15:0] i_out_byte_address,
    input logic [7:0]  i_out_byte_value,
    input logic        i_out_checksum_ok
);
    import ihex_pkg::*;

    logic r_eof_seen;
    logic w_out_beat;

    assign w_out_beat = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eof_seen <= 1'b0;
        end else if (w_out_beat && (i_out_kind == KIND_EOF)) begin
            r_eof_seen <= 1'b1;
        end
    end

    `IHEX_ASSERT_NOW(a_end_fields, i_out_valid && (i_out_kind == KIND_END), i_out_byte_address == 16'd0, "record end with nonzero address")
    `IHEX_ASSERT_NOW(a_eof_fields, i_out_valid && (i_out_kind == KIND_EOF), (i_out_byte_value == 8'd0) && !i_out_checksum_ok, "eof result with stray fields")
    `IHEX_ASSERT_NOW(a_data_ok_low, i_out_valid && (i_out_kind == KIND_DATA), !i_out_checksum_ok, "data beat flags checksum")
    `IHEX_ASSERT_NEXT(a_quiet_after_eof, r_eof_seen, !i_out_valid, "result after end-of-file")

endmodule

bind intel_hex_record_parser_top ihex_checker u_ihex_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_out_kind         (o_out.kind),
    .i_out_byte_address (o_out.byte_address),
    .i_out_byte_value   (o_out.byte_value),
    .i_out_checksum_ok  (o_out.checksum_ok)
);

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Intel HEX record parser testbench
// Streams hex text into the parser with random gaps and output stalls.
// A scoreboard predicts each data, record-end and end-of-file result and
// checks every result beat in order. The run starts with a few hand-built
// records, continues with random records (some truncated, some with a bad
// checksum, junk mixed in) and closes with the end-of-file record.
// ----------------------------------------------------------------------------
module tb;
    import ihex_pkg::*;

    localparam int N_ITEMS      = 850;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        logic [1:0]  kind;
        logic [15:0] byte_address;
        logic [7:0]  byte_value;
        logic        checksum_ok;
    } t_hex_result;

    class hex_scoreboard;
        t_phase      phase;
        bit          second_digit;
        bit          finished;
        logic [3:0]  high_nib;
        logic [7:0]  count;
        logic [7:0]  rec_type;
        logic [7:0]  bytes_done;
        logic [7:0]  sum;
        logic [15:0] addr;
        logic [1:0]  addr_digits;
        t_hex_result pending_q[$];
        int          mismatches;

        function new();
            phase        = PH_IDLE;
            second_digit = 1'b0;
            finished     = 1'b0;
            high_nib     = '0;
            count        = '0;
            rec_type     = '0;
            bytes_done   = '0;
            sum          = '0;
            addr         = '0;
            addr_digits  = '0;
            mismatches   = 0;
        endfunction

        // {is_hex, nibble}
        function logic [4:0] decode_char(input logic [7:0] c);
            if (c >= 8'h30 && c <= 8'h39) return {1'b1, c[3:0]};
            if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h61) + NIB_TEN};
            if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h41) + NIB_TEN};
            return 5'b0;
        endfunction

        function void note_char(input logic [7:0] c);
            logic [4:0]  d;
            logic [7:0]  b;
            t_hex_result r;
            if (finished) return;
            if (c == CHAR_COLON) begin
                phase        = PH_COUNT;
                second_digit = 1'b0;
                high_nib     = '0;
                addr_digits  = '0;
                bytes_done   = '0;
                sum          = '0;
                return;
            end
            d = decode_char(c);
            if (!d[4] || phase == PH_IDLE) return;
            // address is taken digit by digit, not as byte pairs
            if (phase == PH_ADDR) begin
                addr = {addr[11:0], d[3:0]};
                if (addr_digits == 2'd3) begin
                    addr_digits = '0;
                    sum         = sum + addr[15:8] + addr[7:0];
                    phase       = PH_TYPE;
                end else begin
                    addr_digits = addr_digits + 2'd1;
                end
                return;
            end
            if (!second_digit) begin
                high_nib     = d[3:0];
                second_digit = 1'b1;
                return;
            end
            second_digit = 1'b0;
            b            = {high_nib, d[3:0]};
            sum          = sum + b;
            case (phase)
                PH_COUNT: begin
                    count       = b;
                    addr        = '0;
                    addr_digits = '0;
                    phase       = PH_ADDR;
                end
                PH_TYPE: begin
                    rec_type = b;
                    if (b == TYPE_EOF) begin
                        finished = 1'b1;
                        phase    = PH_IDLE;
                        r        = '{KIND_EOF, addr, 8'h00, 1'b0};
                        pending_q.push_back(r);
                    end else begin
                        bytes_done = '0;
                        phase      = (count == 8'h00) ? PH_CSUM : PH_DATA;
                    end
                end
                PH_DATA: begin
                    r          = '{KIND_DATA, addr + 16'(bytes_done), b, 1'b0};
                    bytes_done = bytes_done + 8'd1;
                    if (bytes_done == count) phase = PH_CSUM;
                    if (rec_type == TYPE_DATA) pending_q.push_back(r);
                end
                PH_CSUM: begin
                    phase = PH_IDLE;
                    r     = '{KIND_END, 16'h0000, b, (sum == 8'h00)};
                    pending_q.push_back(r);
                end
                default: ;
            endcase
        endfunction

        function void check_result(input t_hex_result got);
            t_hex_result want;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result kind=%0d addr=%h value=%h ok=%b",
                             got.kind, got.byte_address, got.byte_value, got.checksum_ok);
                return;
            end
            want = pending_q.pop_front();
            if (got.kind !== want.kind || got.byte_address !== want.byte_address ||
                got.byte_value !== want.byte_value || got.checksum_ok !== want.checksum_ok) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"ERROR: expected kind=%0d addr=%h value=%h ok=%b, ",
                              "got kind=%0d addr=%h value=%h ok=%b"},
                             want.kind, want.byte_address, want.byte_value, want.checksum_ok,
                             got.kind, got.byte_address, got.byte_value, got.checksum_ok);
            end
        endfunction

        function int pending();
            return pending_q.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    always #5 i_clk = ~i_clk;

    ihex_in_if  in_ch ();
    ihex_out_if out_ch ();

    intel_hex_record_parser_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    hex_scoreboard sb = new;

    logic [7:0] rec_chars[$];
    int         items_sent = 0;
    int         tx_count   = 0;
    bit         tx_calm    = 1'b0;
    int         cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // beat monitor: inputs feed the predictor, outputs are checked
    always @(posedge i_clk) begin
        t_hex_result got;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) sb.note_char(in_ch.ascii_char);
            if (out_ch.valid && out_ch.ready) begin
                got = '{out_ch.kind, out_ch.byte_address, out_ch.byte_value,
                        out_ch.checksum_ok};
                sb.check_result(got);
            end
        end
    end

    // result sink with random stalls, quiet stretches now and then
    initial begin
        int stall;
        int rx_count;
        bit rx_calm;
        rx_count = 0;
        rx_calm  = 1'b0;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_count % 32 == 0) rx_calm = ($urandom_range(0, 3) == 0);
            rx_count++;
            stall = rx_calm ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    task automatic send_char(input logic [7:0] c);
        int gap;
        if (tx_count % 40 == 0) tx_calm = ($urandom_range(0, 3) == 0);
        tx_count++;
        gap = tx_calm ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.ascii_char <= c;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
    endtask

    task automatic send_junk();
        logic [7:0] c;
        logic [4:0] d;
        do begin
            c = 8'($urandom_range(0, 255));
            d = sb.decode_char(c);
        end while (d[4] || c == CHAR_COLON);
        send_char(c);
    endtask

    task automatic wait_drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < NIB_TEN) return 8'h30 + 8'(n);
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(n - NIB_TEN);
    endfunction

    function automatic void add_byte(input logic [7:0] b);
        rec_chars.push_back(hex_char(b[7:4]));
        rec_chars.push_back(hex_char(b[3:0]));
    endfunction

    // cut > 0 truncates the record to that many characters
    task automatic send_record(input int count, input logic [7:0] rtype,
                               input bit bad_sum, input int cut);
        logic [15:0] a;
        logic [7:0]  s;
        logic [7:0]  b;
        rec_chars.delete();
        rec_chars.push_back(CHAR_COLON);
        a = 16'($urandom);
        if ($urandom_range(0, 7) == 0) a = 16'hFFFF - 16'($urandom_range(0, 4));
        add_byte(8'(count));
        add_byte(a[15:8]);
        add_byte(a[7:0]);
        add_byte(rtype);
        s = 8'(count) + a[15:8] + a[7:0] + rtype;
        for (int i = 0; i < count; i++) begin
            b = 8'($urandom);
            if ($urandom_range(0, 7) == 0) b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            add_byte(b);
            s = s + b;
        end
        s = ~s + 8'd1;
        if (bad_sum) s = s ^ 8'(1 << $urandom_range(0, 7));
        add_byte(s);
        if (cut > 0) while (rec_chars.size() > cut) void'(rec_chars.pop_back());
        foreach (rec_chars[i]) begin
            if ($urandom_range(0, 15) == 0) send_junk();
            send_char(rec_chars[i]);
        end
    endtask

    initial begin
        int         count;
        int         cut;
        logic [7:0] rtype;
        bit         idle_clean;
        bit         paused;
        in_ch.valid      <= 1'b0;
        in_ch.ascii_char <= 8'h00;
        i_rst_n          <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // character extremes and hex digits while idle, all ignored
        send_char(8'h00);
        send_char(8'hFF);
        send_text("7A");
        // address wrap, mixed case, junk between data bytes
        send_text(":02FFFF00aBzcd88");
        // colon mid-record restarts; zero byte count record
        send_text(":0312:0000000000");

        wait_drain();

        idle_clean = 1'b1;
        paused     = 1'b0;
        while (items_sent < N_ITEMS) begin
            if ($urandom_range(0, 9) == 0 && idle_clean) begin
                // noise between records: stray digits and junk
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(0, 1)) send_char(hex_char(4'($urandom)));
                    else send_junk();
                end
            end else begin
                count = ($urandom_range(0, 29) == 0) ? $urandom_range(9, 255)
                                                     : $urandom_range(0, 8);
                if ($urandom_range(0, 3) != 0) begin
                    rtype = TYPE_DATA;
                end else begin
                    do rtype = 8'($urandom); while (rtype == TYPE_EOF);
                end
                cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 10 + 2 * count) : 0;
                send_record(count, rtype, ($urandom_range(0, 4) == 0), cut);
                idle_clean = (cut == 0);
            end
            if (!paused && items_sent > N_ITEMS / 2) begin
                paused = 1'b1;
                wait_drain();
            end
        end

        // end-of-file record, then everything is ignored
        send_text(":00ABCD01");
        send_text("52:0100000000FF");
        in_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
